@@ sv/u8u16_pkg.sv @@
`timescale 1ns / 1ps

package u8u16_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_unit;
    typedef logic [20:0] t_point;
    typedef logic [1:0]  t_kind;

    localparam t_unit  REPL_UNIT   = 16'hfffd;
    localparam t_point MAX_POINT   = 21'h10ffff;
    localparam t_point SURR_LOW    = 21'h00d800;
    localparam t_point SURR_HIGH   = 21'h00dfff;
    localparam t_point PLANE1      = 21'h010000;
    localparam t_point MIN_TWO     = 21'h000080;
    localparam t_point MIN_THREE   = 21'h000800;
    localparam t_unit  HIGH_BASE   = 16'hd800;
    localparam t_unit  LOW_BASE    = 16'hdc00;
    localparam t_unit  MAX_UNITS_RST = 16'd256;

    localparam t_kind KIND_NONE = 2'd0;
    localparam t_kind KIND_UNIT = 2'd1;
    localparam t_kind KIND_PAIR = 2'd2;
    localparam t_kind KIND_TERM = 2'd3;

    localparam int MAX_RESULTS = 4;

endpackage

@@ sv/u8u16_byte_if.sv @@
`timescale 1ns / 1ps

interface u8u16_byte_if;
    logic                valid;
    logic                ready;
    u8u16_pkg::t_byte    byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink (input valid, input byte_value, output ready);
endinterface

@@ sv/u8u16_unit_if.sv @@
`timescale 1ns / 1ps

interface u8u16_unit_if;
    logic                valid;
    logic                ready;
    u8u16_pkg::t_unit    code_unit;
    logic                last;

    modport source (output valid, output code_unit, output last, input ready);
    modport sink (input valid, input code_unit, input last, output ready);
endinterface

@@ sv/utf8_to_utf16_transcoder.sv @@
// output: the first code unit of a byte is offered in the cycle after the byte transfer
// throughput: one byte per cycle while each byte gives at most one code unit and o_unit is ready;
//   a byte giving n units holds the four-entry result register for n output transfers
// reset: synchronous, active low; clears the open sequence, unit count, full flag and
//   result count, and sets max_units to 256
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    u8u16_byte_if.sink         i_byte,
    u8u16_unit_if.source       o_unit
);

    logic [15:0]             r_max_units;
    u8u16_pkg::t_point       r_partial, n_partial;
    logic [2:0]              r_seq_len, n_seq_len;
    logic [2:0]              r_bytes_seen, n_bytes_seen;
    logic [15:0]             r_units_written, n_units_written;
    logic                    r_output_full, n_output_full;
    u8u16_pkg::t_unit        r_unit [u8u16_pkg::MAX_RESULTS];
    u8u16_pkg::t_unit        n_unit [u8u16_pkg::MAX_RESULTS];
    logic [2:0]              r_cnt, n_cnt;
    logic                    r_term, n_term;

    logic                    in_xfer;
    logic                    out_xfer;
    u8u16_pkg::t_byte        b;
    logic                    is_cont;
    u8u16_pkg::t_point       shifted;
    logic [2:0]              bs_inc;
    logic                    seq_done;
    u8u16_pkg::t_point       min_point;
    logic                    bad_value;

    u8u16_pkg::t_kind        lead_kind;
    u8u16_pkg::t_point       lead_point;
    u8u16_pkg::t_point       lead_partial;
    logic [2:0]              lead_len;

    u8u16_pkg::t_kind        kind;
    u8u16_pkg::t_point       point;
    logic [2:0]              repl_k;
    logic                    use_lead;
    logic                    hold_seq;

    logic [15:0]             m_eff;
    logic [15:0]             lim;
    logic [15:0]             avail;
    logic [15:0]             avail2;
    logic [2:0]              emit_e;
    logic                    full1;
    logic                    full2;
    logic [1:0]              pn;
    u8u16_pkg::t_unit        pu0, pu1;
    u8u16_pkg::t_point       offset;
    logic [2:0]              rel;

    assign in_xfer  = i_byte.valid && i_byte.ready;
    assign out_xfer = o_unit.valid && o_unit.ready;

    assign i_byte.ready     = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_unit.ready);
    assign o_unit.valid     = (r_cnt != 3'd0);
    assign o_unit.code_unit = r_unit[0];
    assign o_unit.last      = r_term && (r_cnt == 3'd1);

    assign b        = i_byte.byte_value;
    assign is_cont  = (b[7:6] == 2'b10);
    assign shifted  = {r_partial[14:0], b[5:0]};
    assign bs_inc   = r_bytes_seen + 3'd1;
    assign seq_done = (bs_inc == r_seq_len);

    always_comb begin
        case (r_seq_len)
            3'd2:    min_point = u8u16_pkg::MIN_TWO;
            3'd3:    min_point = u8u16_pkg::MIN_THREE;
            default: min_point = u8u16_pkg::PLANE1;
        endcase
    end

    assign bad_value = (shifted < min_point) || (shifted > u8u16_pkg::MAX_POINT)
                       || (shifted >= u8u16_pkg::SURR_LOW && shifted <= u8u16_pkg::SURR_HIGH);

    // lead byte decode
    always_comb begin
        lead_kind    = u8u16_pkg::KIND_UNIT;
        lead_point   = {5'd0, u8u16_pkg::REPL_UNIT};
        lead_partial = '0;
        lead_len     = 3'd0;
        if (b == 8'd0) begin
            lead_kind = u8u16_pkg::KIND_TERM;
        end else if (b[7] == 1'b0) begin
            lead_point = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            lead_kind    = u8u16_pkg::KIND_NONE;
            lead_partial = {16'd0, b[4:0]};
            lead_len     = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            lead_kind    = u8u16_pkg::KIND_NONE;
            lead_partial = {17'd0, b[3:0]};
            lead_len     = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            lead_kind    = u8u16_pkg::KIND_NONE;
            lead_partial = {18'd0, b[2:0]};
            lead_len     = 3'd4;
        end
    end

    // path select
    always_comb begin
        use_lead = 1'b0;
        hold_seq = 1'b0;
        repl_k   = 3'd0;
        kind     = u8u16_pkg::KIND_NONE;
        point    = shifted;
        if (r_seq_len == 3'd0) begin
            use_lead = 1'b1;
        end else if (!is_cont) begin
            use_lead = 1'b1;
            repl_k   = r_bytes_seen;
        end else if (!seq_done) begin
            hold_seq = 1'b1;
        end else if (bad_value) begin
            repl_k = r_seq_len;
        end else begin
            kind = (shifted >= u8u16_pkg::PLANE1) ? u8u16_pkg::KIND_PAIR
                                                   : u8u16_pkg::KIND_UNIT;
        end
        if (use_lead) begin
            kind  = lead_kind;
            point = lead_point;
        end
    end

    // capacity
    assign m_eff  = (r_max_units == 16'd0) ? 16'd1 : r_max_units;
    assign lim    = m_eff - 16'd1;
    assign avail  = (r_units_written < lim) ? (lim - r_units_written) : 16'd0;
    assign full1  = r_output_full || ({13'd0, repl_k} > avail);
    assign emit_e = r_output_full ? 3'd0
                  : (({13'd0, repl_k} > avail) ? avail[2:0] : repl_k);
    assign avail2 = avail - {13'd0, emit_e};
    assign offset = point - u8u16_pkg::PLANE1;

    always_comb begin
        pn    = 2'd0;
        full2 = full1;
        pu0   = point[15:0];
        pu1   = u8u16_pkg::LOW_BASE | {6'd0, offset[9:0]};
        case (kind)
            u8u16_pkg::KIND_TERM: begin
                pn  = 2'd1;
                pu0 = 16'd0;
            end
            u8u16_pkg::KIND_UNIT: begin
                if (!full1) begin
                    if (avail2 != 16'd0) pn = 2'd1;
                    else full2 = 1'b1;
                end
            end
            u8u16_pkg::KIND_PAIR: begin
                pu0 = u8u16_pkg::HIGH_BASE | {6'd0, offset[19:10]};
                if (!full1) begin
                    if (avail2 >= 16'd2) pn = 2'd2;
                    else full2 = 1'b1;
                end
            end
            default: begin
                pn = 2'd0;
            end
        endcase
    end

    // result register load and drain
    always_comb begin
        n_cnt  = r_cnt;
        n_term = r_term;
        rel    = 3'd0;
        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++) begin
            n_unit[i] = r_unit[i];
        end
        if (out_xfer) begin
            n_cnt = r_cnt - 3'd1;
            for (int i = 0; i < u8u16_pkg::MAX_RESULTS - 1; i++) begin
                n_unit[i] = r_unit[i + 1];
            end
        end
        if (in_xfer) begin
            n_cnt  = emit_e + {1'b0, pn};
            n_term = (kind == u8u16_pkg::KIND_TERM);
            for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++) begin
                rel = 3'(i) - emit_e;
                if (3'(i) < emit_e) n_unit[i] = u8u16_pkg::REPL_UNIT;
                else if (rel == 3'd0) n_unit[i] = pu0;
                else n_unit[i] = pu1;
            end
        end
    end

    // string state
    always_comb begin
        n_partial       = r_partial;
        n_seq_len       = r_seq_len;
        n_bytes_seen    = r_bytes_seen;
        n_units_written = r_units_written;
        n_output_full   = r_output_full;
        if (in_xfer) begin
            if (kind == u8u16_pkg::KIND_TERM) begin
                n_partial       = '0;
                n_seq_len       = 3'd0;
                n_bytes_seen    = 3'd0;
                n_units_written = 16'd0;
                n_output_full   = 1'b0;
            end else if (hold_seq) begin
                n_partial    = shifted;
                n_bytes_seen = bs_inc;
            end else begin
                n_units_written = r_units_written + {13'd0, emit_e} + {14'd0, pn};
                n_output_full   = full2;
                n_partial       = lead_partial;
                n_seq_len       = lead_len;
                n_bytes_seen    = (lead_len != 3'd0) ? 3'd1 : 3'd0;
                if (!use_lead) begin
                    n_partial    = '0;
                    n_seq_len    = 3'd0;
                    n_bytes_seen = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units     <= u8u16_pkg::MAX_UNITS_RST;
            r_partial       <= '0;
            r_seq_len       <= 3'd0;
            r_bytes_seen    <= 3'd0;
            r_units_written <= 16'd0;
            r_output_full   <= 1'b0;
            r_cnt           <= 3'd0;
            r_term          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_units <= i_cfg_data;
            end
            r_partial       <= n_partial;
            r_seq_len       <= n_seq_len;
            r_bytes_seen    <= n_bytes_seen;
            r_units_written <= n_units_written;
            r_output_full   <= n_output_full;
            r_cnt           <= n_cnt;
            r_term          <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++) begin
            r_unit[i] <= n_unit[i];
        end
    end

`ifndef ASSERT_OFF
    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.last) |-> (o_unit.code_unit == 16'd0))
        else $error("last unit is not zero");

    a_seq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_len == 3'd0 && r_bytes_seen == 3'd0)
        || (r_seq_len >= 3'd2 && r_seq_len <= 3'd4 && r_bytes_seen >= 3'd1
            && r_bytes_seen < r_seq_len))
        else $error("open sequence count out of step");

    a_full_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_output_full && i_byte.byte_value != 8'd0) |=> (r_cnt == 3'd0))
        else $error("unit produced after output full");
`endif

endmodule
